[sv/thermtbl_pkg.sv]
// Shared types and constants for the thermistor table interpolator.
package thermtbl_pkg;

  localparam int TEMP_W     = 17;
  localparam int INDEX_W    = 8;
  localparam int IN_RES_W   = 24;
  localparam int COUNT_W    = 9;
  localparam int OFFSET_W   = 8;
  localparam int CFG_DATA_W = 9;
  localparam int FRAC_W     = 7;
  localparam int STEP_W     = 3;
  localparam int SCALE      = 100;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_OFFSET      = 1'b1;

  localparam logic [COUNT_W-1:0]  ENTRY_COUNT_RESET = 9'd201;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET      = 8'hCE;

  typedef struct packed {
    logic                cmd;
    logic [INDEX_W-1:0]  entry_index;
    logic [IN_RES_W-1:0] resistance;
  } in_beat_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_centi;
    logic                     valid_res;
  } out_beat_t;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_LAST,
    RD_NEXT,
    RD_SKIP
  } rd_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_HI,
    ST_RD_LO,
    ST_CHECK,
    ST_WALK,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    tbl_write;
    logic    start;
    rd_sel_t rd_sel;
    logic    cap_hi;
    logic    cap_lo;
    logic    seg_step;
    logic    cap_ops;
    logic    div_start;
    logic    cap_frac;
    logic    end_hi;
    logic    end_lo;
    logic    set_fail;
    logic    res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_small;
    logic r_is_hi;
    logic r_is_lo;
    logic seg_found;
    logic seg_last;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

[sv/thermistor_table_interpolate.sv]
// Top level of the thermistor resistance to temperature table interpolator.
//
//   Channel  Signals                          Direction  Beat
//   in       in_valid, in_ready, in_data      into block table write or convert request
//   out      out_valid, out_ready, out_data   out        temperature and valid flag
//   cfg      cfg_we, cfg_index, cfg_wdata     into block register write, no wait
//
// A table write beat is taken in the idle state and leaves the controller there. A convert
// beat walks up to entry_count - 1 segments, one table read per cycle from the single read port,
// and then runs the bit-serial divider.
// Reset clears the controller and restores the register defaults; the table is not cleared.
// A finished result waits in the output register; a stalled output holds the controller
// in its final state, where neither table writes nor converts are taken.
module thermistor_table_interpolate #(
  parameter int TABLE_DEPTH = 256,
  parameter int RES_BITS    = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [thermtbl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  thermtbl_pkg::in_beat_t              in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output thermtbl_pkg::out_beat_t             out_data
);

  thermtbl_pkg::ctrl_cmd_t cmd;
  thermtbl_pkg::dp_stat_t  stat;

  thermtbl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_cmd  (in_data.cmd),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  thermtbl_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .RES_BITS   (RES_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

[sv/thermtbl_div.sv]
// Restoring divider that produces a small quotient one bit per cycle.
module thermtbl_div #(
  parameter int DIVISOR_W = 24
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic [DIVISOR_W+thermtbl_pkg::FRAC_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]                       divisor,
  output logic [thermtbl_pkg::FRAC_W-1:0]           quotient,
  output logic                                       done
);

  localparam int NW = DIVISOR_W + thermtbl_pkg::FRAC_W;

  logic [NW-1:0]                         rem;
  logic [NW-1:0]                         dd;
  logic [thermtbl_pkg::STEP_W-1:0]       step;
  logic                                  busy;
  logic                                  fits;

  assign fits = (rem >= dd);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == '0);
      if (start) begin
        busy <= 1'b1;
        step <= thermtbl_pkg::STEP_W'(thermtbl_pkg::FRAC_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
        end else begin
          step <= step - thermtbl_pkg::STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dd       <= NW'(divisor) << (thermtbl_pkg::FRAC_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dd;
      end
      quotient <= {quotient[thermtbl_pkg::FRAC_W-2:0], fits};
      dd       <= dd >> 1;
    end
  end

endmodule

[sv/thermtbl_datapath.sv]
// Datapath: configuration, resistance table, segment walk, divider and result register.
module thermtbl_datapath #(
  parameter int TABLE_DEPTH = 256,
  parameter int RES_BITS    = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [thermtbl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  thermtbl_pkg::in_beat_t              in_data,
  input  thermtbl_pkg::ctrl_cmd_t             cmd,
  output thermtbl_pkg::dp_stat_t              stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output thermtbl_pkg::out_beat_t             out_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CW    = ($clog2(TABLE_DEPTH + 1) > thermtbl_pkg::COUNT_W) ?
                         $clog2(TABLE_DEPTH + 1) : thermtbl_pkg::COUNT_W;
  localparam int NW    = RES_BITS + thermtbl_pkg::FRAC_W;
  localparam int SEGW  = IDX_W + thermtbl_pkg::FRAC_W;
  localparam int TW    = thermtbl_pkg::TEMP_W;

  logic [thermtbl_pkg::COUNT_W-1:0]         entry_count;
  logic signed [thermtbl_pkg::OFFSET_W-1:0] offset_degrees;

  logic [RES_BITS-1:0] mem [TABLE_DEPTH];
  logic [RES_BITS-1:0] rdata;
  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    waddr;
  logic                idx_ok;

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_eff;
  logic [RES_BITS-1:0] r;
  logic [RES_BITS-1:0] r_clamp;
  logic [RES_BITS-1:0] a;
  logic [RES_BITS-1:0] lo;
  logic [RES_BITS-1:0] num;
  logic [RES_BITS-1:0] den;
  logic [IDX_W-1:0]    seg;
  logic [thermtbl_pkg::FRAC_W-1:0] frac;
  logic                res_ok;

  logic [NW-1:0]                   dividend;
  logic [thermtbl_pkg::FRAC_W-1:0] quotient;
  logic                            div_done;

  logic signed [TW-1:0] base;
  logic [SEGW-1:0]      seg_scaled;
  logic [TW-1:0]        temp_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= thermtbl_pkg::ENTRY_COUNT_RESET;
      offset_degrees <= thermtbl_pkg::OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        thermtbl_pkg::REG_ENTRY_COUNT: entry_count <= cfg_wdata;
        thermtbl_pkg::REG_OFFSET: offset_degrees <= cfg_wdata[thermtbl_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign idx_ok = (32'(in_data.entry_index) < TABLE_DEPTH);
  assign waddr  = IDX_W'(in_data.entry_index);

  always_comb begin
    case (cmd.rd_sel)
      thermtbl_pkg::RD_ZERO: raddr = '0;
      thermtbl_pkg::RD_LAST: raddr = IDX_W'(count - CW'(1));
      thermtbl_pkg::RD_NEXT: raddr = seg + IDX_W'(1);
      thermtbl_pkg::RD_SKIP: raddr = seg + IDX_W'(2);
      default:               raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_write && idx_ok) begin
      mem[waddr] <= RES_BITS'(in_data.resistance);
    end
    rdata <= mem[raddr];
  end

  assign count_eff = (CW'(entry_count) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) :
                     CW'(entry_count);

  always_comb begin
    if (r < rdata) begin
      r_clamp = rdata;
    end else if (r > a) begin
      r_clamp = a;
    end else begin
      r_clamp = r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r     <= RES_BITS'(in_data.resistance);
      count <= count_eff;
      seg   <= '0;
    end
    if (cmd.cap_hi) begin
      a <= rdata;
    end
    if (cmd.cap_lo) begin
      lo <= rdata;
      r  <= r_clamp;
    end
    if (cmd.seg_step) begin
      a   <= rdata;
      seg <= seg + IDX_W'(1);
    end
    if (cmd.cap_ops) begin
      num <= a - r;
      den <= a - rdata;
    end
    if (cmd.cap_frac) begin
      frac <= (den == '0) ? '0 : quotient;
    end
    if (cmd.end_hi) begin
      seg  <= '0;
      frac <= '0;
    end
    if (cmd.end_lo) begin
      seg  <= IDX_W'(count - CW'(1));
      frac <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_ok <= 1'b0;
    end else if (cmd.set_fail) begin
      res_ok <= 1'b0;
    end else if (cmd.cap_frac || cmd.end_hi || cmd.end_lo) begin
      res_ok <= 1'b1;
    end
  end

  assign dividend = NW'(num) * NW'(thermtbl_pkg::SCALE);

  thermtbl_div #(
    .DIVISOR_W(RES_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(dividend),
    .divisor (den),
    .quotient(quotient),
    .done    (div_done)
  );

  assign base       = TW'(offset_degrees * 17'sd100);
  assign seg_scaled = SEGW'(seg) * SEGW'(thermtbl_pkg::SCALE);
  assign temp_sum   = TW'(base) + TW'(seg_scaled) + TW'(frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data.temp_centi <= res_ok ? signed'(temp_sum) : '0;
      out_data.valid_res  <= res_ok;
    end
  end

  assign stat.count_small = (count < CW'(2));
  assign stat.r_is_hi     = (r == a);
  assign stat.r_is_lo     = (r == lo);
  assign stat.seg_found   = (a >= r) && (rdata <= r);
  assign stat.seg_last    = ((CW+1)'(seg) + (CW+1)'(2)) >= (CW+1)'(count);
  assign stat.div_done    = div_done;
  assign stat.out_free    = !out_valid || out_ready;

endmodule

[sv/thermtbl_ctrl.sv]
// Controller state machine that sequences table writes and conversions.
module thermtbl_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_cmd,
  output logic                    in_ready,
  input  thermtbl_pkg::dp_stat_t  stat,
  output thermtbl_pkg::ctrl_cmd_t cmd
);

  thermtbl_pkg::state_t state;
  thermtbl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= thermtbl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      thermtbl_pkg::ST_IDLE: begin
        if (in_valid && (in_cmd == thermtbl_pkg::CMD_CONVERT)) begin
          state_next = thermtbl_pkg::ST_RD_HI;
        end
      end
      thermtbl_pkg::ST_RD_HI: begin
        state_next = stat.count_small ? thermtbl_pkg::ST_DONE : thermtbl_pkg::ST_RD_LO;
      end
      thermtbl_pkg::ST_RD_LO: state_next = thermtbl_pkg::ST_CHECK;
      thermtbl_pkg::ST_CHECK: begin
        if (stat.r_is_hi || stat.r_is_lo) begin
          state_next = thermtbl_pkg::ST_DONE;
        end else begin
          state_next = thermtbl_pkg::ST_WALK;
        end
      end
      thermtbl_pkg::ST_WALK: begin
        if (stat.seg_found) begin
          state_next = thermtbl_pkg::ST_MUL;
        end else if (stat.seg_last) begin
          state_next = thermtbl_pkg::ST_DONE;
        end
      end
      thermtbl_pkg::ST_MUL: state_next = thermtbl_pkg::ST_DIV;
      thermtbl_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_next = thermtbl_pkg::ST_DONE;
        end
      end
      thermtbl_pkg::ST_DONE: begin
        if (stat.out_free) begin
          state_next = thermtbl_pkg::ST_IDLE;
        end
      end
      default: state_next = thermtbl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = thermtbl_pkg::RD_ZERO;
    in_ready = 1'b0;
    case (state)
      thermtbl_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.tbl_write = in_valid && (in_cmd == thermtbl_pkg::CMD_WRITE);
        cmd.start     = in_valid && (in_cmd == thermtbl_pkg::CMD_CONVERT);
      end
      thermtbl_pkg::ST_RD_HI: begin
        cmd.set_fail = stat.count_small;
        cmd.cap_hi   = !stat.count_small;
        cmd.rd_sel   = thermtbl_pkg::RD_LAST;
      end
      thermtbl_pkg::ST_RD_LO: cmd.cap_lo = 1'b1;
      thermtbl_pkg::ST_CHECK: begin
        cmd.end_hi = stat.r_is_hi;
        cmd.end_lo = !stat.r_is_hi && stat.r_is_lo;
        cmd.rd_sel = thermtbl_pkg::RD_NEXT;
      end
      thermtbl_pkg::ST_WALK: begin
        cmd.rd_sel   = thermtbl_pkg::RD_SKIP;
        cmd.cap_ops  = stat.seg_found;
        cmd.set_fail = !stat.seg_found && stat.seg_last;
        cmd.seg_step = !stat.seg_found && !stat.seg_last;
      end
      thermtbl_pkg::ST_MUL: cmd.div_start = 1'b1;
      thermtbl_pkg::ST_DIV: cmd.cap_frac = stat.div_done;
      thermtbl_pkg::ST_DONE: cmd.res_load = stat.out_free;
      default: ;
    endcase
  end

endmodule
